// ----- rtl/kts_pkg.sv -----
// Shared types, constants and helper functions for the keyed top-k score table.
// Used by kts_cell and keyed_topk_score_table_top; depends on nothing else.
`timescale 1ns / 1ps

package kts_pkg;

	localparam int DEPTH   = 64;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int RANK_W  = 7;
	localparam int KEY_W   = 64;
	localparam int SCORE_W = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [1:0] ACT_SUBMIT = 2'd0;
	localparam logic [1:0] ACT_READ   = 2'd1;
	localparam logic [1:0] ACT_FIND   = 2'd2;

	localparam logic [1:0] POL_BEST    = 2'd0;
	localparam logic [1:0] POL_REPLACE = 2'd1;
	localparam logic [1:0] POL_ADD     = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SORT_DESC = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POLICY    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALLOW_DUP = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ENT   = 2'd3;

	typedef struct packed {
		logic [1:0]                action;
		logic [KEY_W-1:0]          player_key;
		logic signed [SCORE_W-1:0] score_value;
		logic [IDX_W-1:0]          position;
	} item_t;

	typedef struct packed {
		logic                      ok;
		logic [RANK_W-1:0]         rank;
		logic [KEY_W-1:0]          entry_key;
		logic signed [SCORE_W-1:0] entry_score;
		logic [6:0]                entry_count;
	} result_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_NEXT,
		OP_PREV,
		OP_LOAD
	} cell_op_t;

	typedef struct packed {
		logic                      desc;
		logic [KEY_W-1:0]          key;
		logic signed [SCORE_W-1:0] score;
	} bcast_t;

	function automatic logic [DEPTH-1:0] first_one(input logic [DEPTH-1:0] v);
		return v & (~v + 1'b1);
	endfunction

	function automatic logic [DEPTH-1:0] below_mask(input logic [CNT_W-1:0] n);
		logic [DEPTH:0] t;
		t = ({{DEPTH{1'b0}}, 1'b1} << n) - 1'b1;
		return t[DEPTH-1:0];
	endfunction

	function automatic logic [DEPTH-1:0] at_bit(input logic [CNT_W-1:0] n);
		logic [DEPTH:0] t;
		t = {{DEPTH{1'b0}}, 1'b1} << n;
		return t[DEPTH-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] encode(input logic [DEPTH-1:0] h);
		logic [CNT_W-1:0] r;
		r = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (h[i]) begin
				r = r | CNT_W'(i);
			end
		end
		return r;
	endfunction

endpackage

// ----- rtl/kts_cell.sv -----
// One table slot: holds a key and a score, shifts to or from its neighbors,
// and compares itself against the broadcast key and score. Uses kts_pkg.
`timescale 1ns / 1ps

module kts_cell (
	input  logic                               clk,
	input  kts_pkg::cell_op_t                  op,
	input  kts_pkg::bcast_t                    bc,
	input  logic [kts_pkg::KEY_W-1:0]          prev_key,
	input  logic signed [kts_pkg::SCORE_W-1:0] prev_score,
	input  logic [kts_pkg::KEY_W-1:0]          next_key,
	input  logic signed [kts_pkg::SCORE_W-1:0] next_score,
	output logic [kts_pkg::KEY_W-1:0]          key,
	output logic signed [kts_pkg::SCORE_W-1:0] score,
	output logic                               match,
	output logic                               ahead
);

	logic [kts_pkg::KEY_W-1:0]          key_q;
	logic signed [kts_pkg::SCORE_W-1:0] score_q;

	always_ff @(posedge clk) begin
		case (op)
			kts_pkg::OP_NEXT: begin
				key_q   <= next_key;
				score_q <= next_score;
			end
			kts_pkg::OP_PREV: begin
				key_q   <= prev_key;
				score_q <= prev_score;
			end
			kts_pkg::OP_LOAD: begin
				key_q   <= bc.key;
				score_q <= bc.score;
			end
			default: begin
				key_q   <= key_q;
				score_q <= score_q;
			end
		endcase
	end

	assign key   = key_q;
	assign score = score_q;
	assign match = (key_q == bc.key);
	assign ahead = bc.desc ? (bc.score > score_q) : (bc.score < score_q);

endmodule

// ----- rtl/keyed_topk_score_table_top.sv -----
// Top level of the keyed top-k score table: sequencer, config registers, cell row.
// Depends on kts_pkg and kts_cell.
`timescale 1ns / 1ps

// An item is taken when start is high and busy is low; its result word shows on
// result for one cycle with done high, and the receiver cannot stall it. A read,
// a find, a submit whose key is kept as it is, or an unused action is finished
// in the evaluate step; a submit that inserts, drops or moves an entry goes on to
// the slot step. The steps are the key lookup across the cell row, a registered
// evaluate step that also closes the old slot of an entry that moves, a slot step
// for a submit to shift the row and load the new slot, and the registered result
// word. A new item may be started in the cycle that done is high. Config writes
// are always ready and must be made while the block is idle.

module keyed_topk_score_table_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  kts_pkg::item_t                      item,
	output logic                                done,
	output kts_pkg::result_t                    result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [kts_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [kts_pkg::CFG_DATA_W-1:0]      cfg_data
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_EVAL,
		S_SLOT
	} state_t;

	state_t state_q, state_d;

	logic       sort_desc_q;
	logic [1:0] policy_q;
	logic       allow_dup_q;
	logic [6:0] max_ent_q;
	logic [kts_pkg::CNT_W-1:0] used_q, used_d;

	kts_pkg::item_t                     in_q;
	logic [kts_pkg::DEPTH-1:0]          hot_q;
	logic                               found_q;
	logic signed [kts_pkg::SCORE_W-1:0] old_q;
	logic                               rd_ok_q;
	logic [kts_pkg::KEY_W-1:0]          rd_key_q;
	logic signed [kts_pkg::SCORE_W-1:0] rd_score_q;
	logic signed [kts_pkg::SCORE_W-1:0] cmp_q, cmp_d;
	logic                               reins_q, reins_d;

	kts_pkg::result_t res_q, res_d;
	logic             done_q, done_d;

	kts_pkg::cell_op_t                  op_v [kts_pkg::DEPTH];
	logic [kts_pkg::KEY_W-1:0]          key_v [kts_pkg::DEPTH];
	logic signed [kts_pkg::SCORE_W-1:0] score_v [kts_pkg::DEPTH];
	logic [kts_pkg::KEY_W-1:0]          pkey_v [kts_pkg::DEPTH];
	logic signed [kts_pkg::SCORE_W-1:0] pscore_v [kts_pkg::DEPTH];
	logic [kts_pkg::KEY_W-1:0]          nkey_v [kts_pkg::DEPTH];
	logic signed [kts_pkg::SCORE_W-1:0] nscore_v [kts_pkg::DEPTH];
	logic [kts_pkg::DEPTH-1:0]          match_v, ahead_v;
	kts_pkg::bcast_t                    bc;

	logic [kts_pkg::DEPTH-1:0]          used_mask, look_hot, pos_hot;
	logic                               look_found, look_rd_ok;
	logic signed [kts_pkg::SCORE_W-1:0] look_old, look_rd_score;
	logic [kts_pkg::KEY_W-1:0]          look_rd_key;

	logic [kts_pkg::CNT_W-1:0]          lim, hot_idx, n_slot, p_idx;
	logic [kts_pkg::DEPTH-1:0]          ge_hot, slot_hot, gt_slot;
	logic signed [kts_pkg::SCORE_W-1:0] sum, new_score;
	logic                               change, ins, do_remove;
	logic [kts_pkg::CNT_W:0]            used_inc;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = res_q;

	assign bc.desc  = sort_desc_q;
	assign bc.key   = in_q.player_key;
	assign bc.score = cmp_q;

	always_comb begin
		for (int i = 0; i < kts_pkg::DEPTH; i++) begin
			pkey_v[i]   = (i == 0) ? key_v[i] : key_v[(i == 0) ? 0 : i - 1];
			pscore_v[i] = (i == 0) ? score_v[i] : score_v[(i == 0) ? 0 : i - 1];
			nkey_v[i]   = (i == kts_pkg::DEPTH - 1) ? key_v[i] :
				key_v[(i == kts_pkg::DEPTH - 1) ? i : i + 1];
			nscore_v[i] = (i == kts_pkg::DEPTH - 1) ? score_v[i] :
				score_v[(i == kts_pkg::DEPTH - 1) ? i : i + 1];
		end
	end

	for (genvar g = 0; g < kts_pkg::DEPTH; g++) begin : g_cell
		kts_cell u_cell (
			.clk        (clk),
			.op         (op_v[g]),
			.bc         (bc),
			.prev_key   (pkey_v[g]),
			.prev_score (pscore_v[g]),
			.next_key   (nkey_v[g]),
			.next_score (nscore_v[g]),
			.key        (key_v[g]),
			.score      (score_v[g]),
			.match      (match_v[g]),
			.ahead      (ahead_v[g])
		);
	end

	// lookup stage
	always_comb begin
		used_mask     = kts_pkg::below_mask(used_q);
		look_hot      = kts_pkg::first_one(match_v & used_mask);
		look_found    = |look_hot;
		look_old      = '0;
		look_rd_key   = '0;
		look_rd_score = '0;
		for (int i = 0; i < kts_pkg::DEPTH; i++) begin
			pos_hot[i] = (kts_pkg::CNT_W'(in_q.position) == kts_pkg::CNT_W'(i));
			if (look_hot[i]) begin
				look_old = look_old | score_v[i];
			end
			if (pos_hot[i]) begin
				look_rd_key   = look_rd_key | key_v[i];
				look_rd_score = look_rd_score | score_v[i];
			end
		end
		look_rd_ok = (kts_pkg::CNT_W'(in_q.position) < used_q);
	end

	// evaluate and slot stages
	always_comb begin
		if (max_ent_q == 7'd0) begin
			lim = kts_pkg::CNT_W'(1);
		end else if (int'(max_ent_q) > kts_pkg::DEPTH) begin
			lim = kts_pkg::CNT_W'(kts_pkg::DEPTH);
		end else begin
			lim = kts_pkg::CNT_W'(max_ent_q);
		end

		hot_idx = kts_pkg::encode(hot_q);
		ge_hot  = ~(hot_q - 1'b1);

		sum = old_q + in_q.score_value;
		if ((old_q[kts_pkg::SCORE_W-1] == in_q.score_value[kts_pkg::SCORE_W-1]) &&
			(sum[kts_pkg::SCORE_W-1] != old_q[kts_pkg::SCORE_W-1])) begin
			sum = old_q[kts_pkg::SCORE_W-1] ? {1'b1, {(kts_pkg::SCORE_W-1){1'b0}}} :
				{1'b0, {(kts_pkg::SCORE_W-1){1'b1}}};
		end
		case (policy_q)
			kts_pkg::POL_REPLACE: begin
				new_score = in_q.score_value;
				change    = 1'b1;
			end
			kts_pkg::POL_ADD: begin
				new_score = sum;
				change    = 1'b1;
			end
			default: begin
				new_score = in_q.score_value;
				change    = sort_desc_q ? (in_q.score_value > old_q) :
					(in_q.score_value < old_q);
			end
		endcase

		n_slot   = reins_q ? (used_q - 1'b1) : used_q;
		slot_hot = kts_pkg::first_one((ahead_v & kts_pkg::below_mask(n_slot)) |
			kts_pkg::at_bit(n_slot));
		gt_slot  = ~((slot_hot - 1'b1) | slot_hot);
		p_idx    = (|slot_hot) ? kts_pkg::encode(slot_hot) : n_slot;
		ins      = reins_q || (p_idx < lim);
		used_inc = {1'b0, used_q} + 1'b1;

		do_remove = 1'b0;
		state_d   = state_q;
		used_d    = used_q;
		cmp_d     = cmp_q;
		reins_d   = reins_q;
		done_d    = 1'b0;
		res_d     = '0;
		res_d.entry_count = 7'(used_q);

		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				state_d = S_EVAL;
			end
			S_EVAL: begin
				case (in_q.action)
					kts_pkg::ACT_SUBMIT: begin
						if (found_q && !allow_dup_q) begin
							if (change) begin
								do_remove = 1'b1;
								cmp_d     = new_score;
								reins_d   = 1'b1;
								state_d   = S_SLOT;
							end else begin
								done_d            = 1'b1;
								res_d.ok          = 1'b1;
								res_d.rank        = kts_pkg::RANK_W'(hot_idx + 1'b1);
								res_d.entry_key   = in_q.player_key;
								res_d.entry_score = old_q;
								state_d           = S_IDLE;
							end
						end else begin
							cmp_d   = in_q.score_value;
							reins_d = 1'b0;
							state_d = S_SLOT;
						end
					end
					kts_pkg::ACT_READ: begin
						done_d   = 1'b1;
						res_d.ok = rd_ok_q;
						if (rd_ok_q) begin
							res_d.rank        = kts_pkg::RANK_W'(in_q.position) + 1'b1;
							res_d.entry_key   = rd_key_q;
							res_d.entry_score = rd_score_q;
						end
						state_d = S_IDLE;
					end
					kts_pkg::ACT_FIND: begin
						done_d   = 1'b1;
						res_d.ok = found_q;
						if (found_q) begin
							res_d.rank        = kts_pkg::RANK_W'(hot_idx + 1'b1);
							res_d.entry_key   = in_q.player_key;
							res_d.entry_score = old_q;
						end
						state_d = S_IDLE;
					end
					default: begin
						done_d  = 1'b1;
						state_d = S_IDLE;
					end
				endcase
			end
			S_SLOT: begin
				if (!reins_q) begin
					used_d = (used_inc < {1'b0, lim}) ? used_inc[kts_pkg::CNT_W-1:0] : lim;
				end
				done_d   = 1'b1;
				res_d.ok = 1'b1;
				if (ins) begin
					res_d.rank        = kts_pkg::RANK_W'(p_idx + 1'b1);
					res_d.entry_key   = in_q.player_key;
					res_d.entry_score = cmp_q;
				end
				res_d.entry_count = 7'(used_d);
				state_d           = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		for (int i = 0; i < kts_pkg::DEPTH; i++) begin
			op_v[i] = kts_pkg::OP_HOLD;
			if (do_remove && ge_hot[i]) begin
				op_v[i] = kts_pkg::OP_NEXT;
			end else if (state_q == S_SLOT && ins) begin
				if (slot_hot[i]) begin
					op_v[i] = kts_pkg::OP_LOAD;
				end else if (gt_slot[i]) begin
					op_v[i] = kts_pkg::OP_PREV;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			sort_desc_q <= 1'b1;
			policy_q    <= kts_pkg::POL_BEST;
			allow_dup_q <= 1'b0;
			max_ent_q   <= 7'd64;
			done_q      <= 1'b0;
			res_q       <= '0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			done_q  <= done_d;
			if (done_d) begin
				res_q <= res_d;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					kts_pkg::REG_SORT_DESC: sort_desc_q <= cfg_data[0];
					kts_pkg::REG_POLICY:    policy_q    <= cfg_data[1:0];
					kts_pkg::REG_ALLOW_DUP: allow_dup_q <= cfg_data[0];
					kts_pkg::REG_MAX_ENT:   max_ent_q   <= cfg_data[6:0];
					default: begin
						max_ent_q <= max_ent_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			in_q <= item;
		end
		if (state_q == S_LOOK) begin
			hot_q      <= look_hot;
			found_q    <= look_found;
			old_q      <= look_old;
			rd_ok_q    <= look_rd_ok;
			rd_key_q   <= look_rd_key;
			rd_score_q <= look_rd_score;
		end
		cmp_q   <= cmp_d;
		reins_q <= reins_d;
	end

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy))
		else $error("result word without a preceding busy cycle");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= kts_pkg::CNT_W'(kts_pkg::DEPTH))
		else $error("entry count beyond table depth");

	a_miss_rank: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !res_q.ok) |-> (res_q.rank == '0 && res_q.entry_key == '0))
		else $error("miss reported with an entry");

endmodule
